FILE: rtl/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg: shared types and constants of the ADTS frame deframer
// Sync pattern, header sizes, status codes, the result record and the
// sampling rate lookup.
// ----------------------------------------------------------------------------
package afd_pkg;

  // sync pair
  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] SYNC2_MASK = 8'hF6;
  localparam logic [7:0] SYNC2_VAL  = 8'hF0;

  // header sizes in bytes, without and with crc
  localparam logic [3:0] HDR_BASE = 4'd7;
  localparam logic [3:0] HDR_CRC  = 4'd9;

  // depth of the header delay line in bytes
  localparam logic [2:0] LINE_DEPTH = 3'd7;

  // default rate index used when the header index is out of range
  localparam logic [3:0] RATE_IDX_DEFAULT = 4'd3;
  localparam logic [3:0] RATE_IDX_COUNT   = 4'd12;

  // channel configuration substituted for zero
  localparam logic [2:0] CHAN_DEFAULT = 3'd2;

  // result status codes
  localparam logic [1:0] ST_FRAME  = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  REG_KEEP_HEADER = 1'b0;

  // one result request
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [12:0] frame_bytes;
    logic [3:0]  header_bytes;
    logic [1:0]  profile;
    logic [16:0] sample_rate;
    logic [2:0]  channels;
  } res_t;

  // sampling frequency index to hertz
  function automatic logic [16:0] rate_hz(input logic [3:0] idx);
    logic [16:0] hz;
    case (idx)
      4'd0:    hz = 17'd96000;
      4'd1:    hz = 17'd88200;
      4'd2:    hz = 17'd64000;
      4'd3:    hz = 17'd48000;
      4'd4:    hz = 17'd44100;
      4'd5:    hz = 17'd32000;
      4'd6:    hz = 17'd24000;
      4'd7:    hz = 17'd22050;
      4'd8:    hz = 17'd16000;
      4'd9:    hz = 17'd12000;
      4'd10:   hz = 17'd11025;
      4'd11:   hz = 17'd8000;
      default: hz = 17'd48000;
    endcase
    return hz;
  endfunction

endpackage

FILE: rtl/afd_ifs.sv
// ----------------------------------------------------------------------------
// afd_ifs: stream channels of the ADTS frame deframer
// Byte input channel and frame result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface afd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface afd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic        first_of_frame;
  logic        last_of_frame;
  logic [12:0] frame_bytes;
  logic [3:0]  header_bytes;
  logic [1:0]  profile;
  logic [16:0] sample_rate;
  logic [2:0]  channels;

  modport source (output valid, output out_byte, output status, output first_of_frame,
                  output last_of_frame, output frame_bytes, output header_bytes,
                  output profile, output sample_rate, output channels, input ready);
  modport sink (input valid, input out_byte, input status, input first_of_frame,
                input last_of_frame, input frame_bytes, input header_bytes,
                input profile, input sample_rate, input channels, output ready);
  modport monitor (input valid, input ready, input out_byte, input status,
                   input first_of_frame, input last_of_frame, input frame_bytes,
                   input header_bytes, input profile, input sample_rate, input channels);
endinterface

FILE: rtl/adts_frame_deframer.sv
// ----------------------------------------------------------------------------
// adts_frame_deframer: ADTS stream to frame bytes
// Hunts for ADTS sync, parses the header and passes frame bytes on with
// first/last marks, flagging empty and bad-length frames.
//
//   channel   ports                      direction  payload
//   in_ch     valid/ready handshake      sink       data_byte
//   out_ch    valid/ready handshake      source     frame byte, status, props
//   config    psel/penable/pwrite/...    slave      keep_header at 0x0
//
// One byte request is taken every cycle while no stalled result blocks it;
// its result passes through the input register, then the result register.
// With keep_header set, frame bytes leave through a 7-byte delay line, so a
// byte is emitted seven input requests after it arrives.
// rst_n is synchronous: framing returns to sync hunt, properties unlatched.
// A stalled output holds its request; input keeps flowing while the byte
// makes no result or the result register is free or drained in the same cycle.
// ----------------------------------------------------------------------------
module adts_frame_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  afd_in_if.sink                           in_ch,
  afd_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [afd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [afd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [afd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import afd_pkg::*;

  logic       keep_header;
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       out_v_r;
  res_t       res_r;
  res_t       res;
  logic       emit;
  logic       fire;

  // configuration
  afd_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .keep_header (keep_header)
  );

  // a byte is processed when its result, if any, has a free slot
  assign fire        = in_v_r && (!emit || !out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.data_byte;
    end
  end

  // framing core
  afd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .byte_in     (in_byte_r),
    .keep_header (keep_header),
    .emit        (emit),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.out_byte       = res_r.out_byte;
  assign out_ch.status         = res_r.status;
  assign out_ch.first_of_frame = res_r.first_of_frame;
  assign out_ch.last_of_frame  = res_r.last_of_frame;
  assign out_ch.frame_bytes    = res_r.frame_bytes;
  assign out_ch.header_bytes   = res_r.header_bytes;
  assign out_ch.profile        = res_r.profile;
  assign out_ch.sample_rate    = res_r.sample_rate;
  assign out_ch.channels       = res_r.channels;

endmodule

FILE: rtl/afd_apb_regs.sv
// ----------------------------------------------------------------------------
// afd_apb_regs: configuration register file
// APB-style write/read of the keep_header control bit.
// ----------------------------------------------------------------------------
module afd_apb_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [afd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [afd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [afd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic                             keep_header
);
  import afd_pkg::*;

  logic keep_r;
  logic wr_en;
  logic hit_keep;

  // word decode, byte offset bits ignored
  assign hit_keep = (paddr[CFG_ADDR_W-1 -: 1] == REG_KEEP_HEADER);
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= 1'b0;
    end else if (wr_en && hit_keep) begin
      keep_r <= pwdata[0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (hit_keep) begin
      prdata[0] = keep_r;
    end
  end

  assign keep_header = keep_r;

endmodule

FILE: rtl/afd_core.sv
// ----------------------------------------------------------------------------
// afd_core: ADTS sync hunt, header parse and frame byte selection
// Holds the framing state and the 7-byte delay line, and forms the
// result request for the byte presented on byte_in.
// ----------------------------------------------------------------------------
module afd_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    byte_in,
  input  logic          keep_header,
  output logic          emit,
  output afd_pkg::res_t res
);
  import afd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SYNC = 2'd1,
    PH_HDR  = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [55:0] shift_r, shift_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [12:0] left_r, left_nxt;
  logic        latched_r, latched_nxt;
  logic [1:0]  prof_r, prof_nxt;
  logic [3:0]  ridx_r, ridx_nxt;
  logic [2:0]  chan_r, chan_nxt;
  logic [12:0] len_r, len_nxt;
  logic [3:0]  hsz_r, hsz_nxt;
  logic        keep_r, keep_nxt;
  logic [2:0]  line_r, line_nxt;
  logic [1:0]  pend_r, pend_nxt;

  logic        line_emit;
  logic        pay_emit;
  logic        pend_emit;
  logic [1:0]  pend_code;
  logic [13:0] remaining;
  logic [2:0]  line_mid;
  logic [12:0] payload;
  logic [12:0] hdr_len;
  logic [3:0]  hdr_size;
  logic [3:0]  hdr_ridx;
  logic [2:0]  hdr_chan;

  // delay line output and payload window
  assign line_emit = (line_r != 3'd0);
  assign remaining = {1'b0, left_r} + {11'd0, line_r};
  assign line_mid  = line_r - {2'd0, line_emit};
  assign payload   = (len_r > {9'd0, hsz_r}) ? (len_r - {9'd0, hsz_r}) : 13'd0;
  assign shift_nxt = {shift_r[47:0], byte_in};

  // header fields of the completed 7-byte header
  assign hdr_len  = shift_nxt[25:13];
  assign hdr_size = shift_nxt[40] ? HDR_BASE : HDR_CRC;
  assign hdr_ridx = shift_nxt[37:34];
  assign hdr_chan = shift_nxt[32:30];

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    hcnt_nxt    = hcnt_r;
    left_nxt    = left_r;
    latched_nxt = latched_r;
    prof_nxt    = prof_r;
    ridx_nxt    = ridx_r;
    chan_nxt    = chan_r;
    len_nxt     = len_r;
    hsz_nxt     = hsz_r;
    keep_nxt    = keep_r;
    line_nxt    = line_mid;
    pend_nxt    = pend_r;
    pay_emit    = 1'b0;
    case (phase_r)
      PH_BODY: begin
        left_nxt = left_r - {12'd0, (left_r != 13'd0)};
        if (keep_r) begin
          if (line_mid < LINE_DEPTH) begin
            line_nxt = line_mid + 3'd1;
          end
        end else begin
          pay_emit = !line_emit && (left_r != 13'd0) && (left_r <= payload);
        end
        if (left_nxt == 13'd0) begin
          phase_nxt = PH_HUNT;
          hcnt_nxt  = 4'd0;
        end
      end
      PH_HUNT: begin
        if (byte_in == SYNC_BYTE) begin
          phase_nxt = PH_SYNC;
          hcnt_nxt  = 4'd1;
        end
      end
      PH_SYNC: begin
        if ((byte_in & SYNC2_MASK) == SYNC2_VAL) begin
          phase_nxt = PH_HDR;
          hcnt_nxt  = 4'd2;
        end else if (byte_in == SYNC_BYTE) begin
          hcnt_nxt = 4'd1;
        end else begin
          phase_nxt = PH_HUNT;
          hcnt_nxt  = 4'd0;
        end
      end
      PH_HDR: begin
        hcnt_nxt = hcnt_r + 4'd1;
        if (hcnt_nxt >= HDR_BASE) begin
          // properties come from the first header only
          if (!latched_r) begin
            prof_nxt    = shift_nxt[39:38];
            ridx_nxt    = (hdr_ridx >= RATE_IDX_COUNT) ? RATE_IDX_DEFAULT : hdr_ridx;
            chan_nxt    = (hdr_chan == 3'd0) ? CHAN_DEFAULT : hdr_chan;
            latched_nxt = 1'b1;
          end
          len_nxt  = hdr_len;
          hsz_nxt  = hdr_size;
          hcnt_nxt = 4'd0;
          if (hdr_len <= {9'd0, hdr_size}) begin
            // short frame: flag and hunt again
            pend_nxt  = (hdr_len == {9'd0, hdr_size}) ? ST_EMPTY : ST_BADLEN;
            phase_nxt = PH_HUNT;
          end else begin
            keep_nxt  = keep_header;
            left_nxt  = hdr_len - {9'd0, HDR_BASE};
            phase_nxt = PH_BODY;
            if (keep_header) begin
              line_nxt = LINE_DEPTH;
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    // status goes out when no frame byte claims the slot
    pend_code = pend_nxt;
    pend_emit = !line_emit && !pay_emit && (pend_code != ST_FRAME);
    if (pend_emit) begin
      pend_nxt = ST_FRAME;
    end
  end

  // result request
  always_comb begin
    res.profile     = prof_nxt;
    res.sample_rate = rate_hz(ridx_nxt);
    res.channels    = chan_nxt;
    if (line_emit) begin
      res.out_byte       = shift_r[55:48];
      res.status         = ST_FRAME;
      res.first_of_frame = (remaining == {1'b0, len_r});
      res.last_of_frame  = (remaining == 14'd1);
      res.frame_bytes    = len_r;
      res.header_bytes   = hsz_r;
    end else if (pay_emit) begin
      res.out_byte       = byte_in;
      res.status         = ST_FRAME;
      res.first_of_frame = (left_r == payload);
      res.last_of_frame  = (left_r == 13'd1);
      res.frame_bytes    = payload;
      res.header_bytes   = hsz_r;
    end else begin
      res.out_byte       = 8'd0;
      res.status         = pend_code;
      res.first_of_frame = 1'b0;
      res.last_of_frame  = 1'b0;
      res.frame_bytes    = len_nxt;
      res.header_bytes   = hsz_nxt;
    end
  end

  assign emit = line_emit || pay_emit || pend_emit;

  // framing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hcnt_r    <= 4'd0;
      left_r    <= 13'd0;
      latched_r <= 1'b0;
      prof_r    <= 2'd0;
      ridx_r    <= 4'd0;
      chan_r    <= 3'd0;
      len_r     <= 13'd0;
      hsz_r     <= 4'd0;
      keep_r    <= 1'b0;
      line_r    <= 3'd0;
      pend_r    <= ST_FRAME;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      hcnt_r    <= hcnt_nxt;
      left_r    <= left_nxt;
      latched_r <= latched_nxt;
      prof_r    <= prof_nxt;
      ridx_r    <= ridx_nxt;
      chan_r    <= chan_nxt;
      len_r     <= len_nxt;
      hsz_r     <= hsz_nxt;
      keep_r    <= keep_nxt;
      line_r    <= line_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // delay line, no reset needed
  always_ff @(posedge clk) begin
    if (fire) begin
      shift_r <= shift_nxt;
    end
  end

endmodule

FILE: rtl/afd_checker.sv
// ----------------------------------------------------------------------------
// afd_checker: port-level checks of the ADTS frame deframer
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module afd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [1:0]  out_status,
  input logic        out_first,
  input logic        out_last,
  input logic [3:0]  out_hdr_bytes,
  input logic [16:0] out_rate,
  input logic [2:0]  out_chan
);
  import afd_pkg::*;

  // stalled result request holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_byte) && $stable(out_status))
    else $error("result changed while stalled");

  // status results carry no byte and no marks
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FRAME) |->
      (out_byte == 8'd0) && !out_first && !out_last)
    else $error("status result with frame byte content");

  // header size is one of the two legal sizes
  a_hdr_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hdr_bytes == HDR_BASE) || (out_hdr_bytes == HDR_CRC))
    else $error("bad header size");

  // latched properties are always usable
  a_props: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_chan != 3'd0) && (out_rate != 17'd0))
    else $error("unlatched properties on result");

endmodule

bind adts_frame_deframer afd_checker u_afd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .out_status    (out_ch.status),
  .out_first     (out_ch.first_of_frame),
  .out_last      (out_ch.last_of_frame),
  .out_hdr_bytes (out_ch.header_bytes),
  .out_rate      (out_ch.sample_rate),
  .out_chan      (out_ch.channels)
);
